[hdl/egdp_pkg.sv]
package egdp_pkg;

  localparam logic [7:0] DESC_TAG     = 8'hD6;
  localparam int         FIFO_DEPTH   = 4;
  localparam int         FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int         FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam logic [3:0] GRP_RELAY_A  = 4'd4;
  localparam logic [3:0] GRP_RELAY_B  = 4'd5;
  localparam logic [2:0] EVT_LAST_IDX = 3'd3;
  localparam logic [2:0] RLY_LAST_IDX = 3'd7;
  localparam logic [7:0] EVT_REC_LEN  = 8'd4;
  localparam logic [7:0] RLY_REC_LEN  = 8'd8;

  typedef enum logic [2:0] {
    KIND_EVENT = 3'd0,
    KIND_RELAY = 3'd1,
    KIND_PRIV  = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ERROR = 3'd4
  } egdp_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SMALLBUF = 3'd1,
    ERR_BADTAG   = 3'd2,
    ERR_TOOLONG  = 3'd3,
    ERR_ZEROLEN  = 3'd4,
    ERR_OVERRUN  = 3'd5
  } egdp_err_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LEN   = 3'd1,
    PH_HEAD  = 3'd2,
    PH_EVT   = 3'd3,
    PH_RELAY = 3'd4,
    PH_PRIV  = 3'd5
  } egdp_phase_t;

  typedef enum logic [1:0] {
    END_NONE = 2'd0,
    END_DONE = 2'd1,
    END_FAIL = 2'd2
  } egdp_end_t;

  typedef struct packed {
    logic        start_req;
    logic [7:0]  data_byte;
    logic [15:0] data_size;
  } egdp_in_t;

  typedef struct packed {
    egdp_kind_t  kind;
    logic [3:0]  grp_code;
    logic [15:0] service_ident;
    logic [15:0] event_ident;
    logic [15:0] network_ident;
    logic [15:0] stream_ident;
    logic [7:0]  private_value;
    egdp_err_t   error_code;
    logic [8:0]  consumed_length;
    logic        last;
  } egdp_out_t;

  // One queue entry: the first result of a byte plus an optional
  // terminating done/error result that follows it.
  typedef struct packed {
    egdp_out_t  head;
    logic       tail_vld;
    egdp_kind_t tail_kind;
    egdp_err_t  tail_err;
    logic [8:0] tail_len;
  } egdp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } egdp_fifo_stat_t;

endpackage

[hdl/egdp_front.sv]
module egdp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  egdp_pkg::egdp_in_t in_item,
  output logic              push,
  output egdp_pkg::egdp_cmd_t cmd
);

  egdp_pkg::egdp_phase_t phase_r, phase_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic [7:0]  dlen_r, dlen_nxt;
  logic [3:0]  events_r, events_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [55:0] asm_r, asm_nxt;
  logic [3:0]  grp_r, grp_nxt;
  logic [15:0] bufsz_r, bufsz_nxt;

  logic [7:0]  b;
  logic [7:0]  rem_dec;
  logic [63:0] full_rec;
  logic        small_buf, bad_tag, too_long, zero_len;
  logic [3:0]  evl_a, grp_a;
  egdp_pkg::egdp_phase_t adv_to;
  egdp_pkg::egdp_end_t   adv_end;
  logic [8:0]  cons_len;
  logic        evt_end, rly_end;

  assign b         = in_item.data_byte;
  assign rem_dec   = remain_r - 8'd1;
  assign full_rec  = {asm_r, b};
  assign small_buf = in_item.data_size < 16'd2;
  assign bad_tag   = b != egdp_pkg::DESC_TAG;
  assign too_long  = ({9'd0, b} + 17'd2) > {1'b0, bufsz_r};
  assign zero_len  = b == 8'd0;
  assign cons_len  = {1'b0, dlen_r} + 9'd2;
  assign evt_end   = idx_r == egdp_pkg::EVT_LAST_IDX;
  assign rly_end   = idx_r == egdp_pkg::RLY_LAST_IDX;

  // Segment completion: what follows the header or a finished record.
  always_comb begin
    evl_a = events_r;
    grp_a = grp_r;
    if (phase_r == egdp_pkg::PH_HEAD) begin
      evl_a = b[3:0];
      grp_a = b[7:4];
    end else if (phase_r == egdp_pkg::PH_EVT) begin
      evl_a = events_r - 4'd1;
    end
    adv_to  = egdp_pkg::PH_IDLE;
    adv_end = egdp_pkg::END_NONE;
    if (evl_a != 4'd0) begin
      if (rem_dec < egdp_pkg::EVT_REC_LEN) begin
        adv_end = egdp_pkg::END_FAIL;
      end else begin
        adv_to = egdp_pkg::PH_EVT;
      end
    end else if (rem_dec == 8'd0) begin
      adv_end = egdp_pkg::END_DONE;
    end else if (grp_a == egdp_pkg::GRP_RELAY_A || grp_a == egdp_pkg::GRP_RELAY_B) begin
      if (rem_dec < egdp_pkg::RLY_REC_LEN) begin
        adv_end = egdp_pkg::END_FAIL;
      end else begin
        adv_to = egdp_pkg::PH_RELAY;
      end
    end else begin
      adv_to = egdp_pkg::PH_PRIV;
    end
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (in_item.start_req) begin
        phase_nxt = (small_buf || bad_tag) ? egdp_pkg::PH_IDLE : egdp_pkg::PH_LEN;
      end else begin
        unique case (phase_r)
          egdp_pkg::PH_LEN:   phase_nxt = (too_long || zero_len) ? egdp_pkg::PH_IDLE
                                                                 : egdp_pkg::PH_HEAD;
          egdp_pkg::PH_HEAD:  phase_nxt = adv_to;
          egdp_pkg::PH_EVT:   phase_nxt = evt_end ? adv_to : egdp_pkg::PH_EVT;
          egdp_pkg::PH_RELAY: phase_nxt = rly_end ? adv_to : egdp_pkg::PH_RELAY;
          egdp_pkg::PH_PRIV:  phase_nxt = (rem_dec == 8'd0) ? egdp_pkg::PH_IDLE
                                                            : egdp_pkg::PH_PRIV;
          default:            phase_nxt = egdp_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Outputs towards the queue.
  always_comb begin
    push = 1'b0;
    cmd  = '0;
    cmd.head.grp_code = (phase_r == egdp_pkg::PH_HEAD) ? b[7:4] : grp_r;
    cmd.tail_len = cons_len;
    if (acc) begin
      if (in_item.start_req) begin
        cmd.head.grp_code = 4'd0;
        if (small_buf || bad_tag) begin
          push = 1'b1;
          cmd.head.kind = egdp_pkg::KIND_ERROR;
          cmd.head.error_code = small_buf ? egdp_pkg::ERR_SMALLBUF : egdp_pkg::ERR_BADTAG;
        end
      end else begin
        unique case (phase_r)
          egdp_pkg::PH_LEN: begin
            if (too_long || zero_len) begin
              push = 1'b1;
              cmd.head.kind = egdp_pkg::KIND_ERROR;
              cmd.head.error_code = too_long ? egdp_pkg::ERR_TOOLONG : egdp_pkg::ERR_ZEROLEN;
            end
          end
          egdp_pkg::PH_HEAD: begin
            if (adv_end == egdp_pkg::END_DONE) begin
              push = 1'b1;
              cmd.head.kind = egdp_pkg::KIND_DONE;
              cmd.head.consumed_length = cons_len;
            end else if (adv_end == egdp_pkg::END_FAIL) begin
              push = 1'b1;
              cmd.head.kind = egdp_pkg::KIND_ERROR;
              cmd.head.error_code = egdp_pkg::ERR_OVERRUN;
            end
          end
          egdp_pkg::PH_EVT, egdp_pkg::PH_RELAY: begin
            if ((phase_r == egdp_pkg::PH_EVT) ? evt_end : rly_end) begin
              push = 1'b1;
              cmd.head.kind = (phase_r == egdp_pkg::PH_EVT) ? egdp_pkg::KIND_EVENT
                                                            : egdp_pkg::KIND_RELAY;
              cmd.head.service_ident = full_rec[31:16];
              cmd.head.event_ident   = full_rec[15:0];
              if (phase_r == egdp_pkg::PH_RELAY) begin
                cmd.head.network_ident = full_rec[63:48];
                cmd.head.stream_ident  = full_rec[47:32];
              end
              cmd.tail_vld  = adv_end != egdp_pkg::END_NONE;
              cmd.tail_kind = (adv_end == egdp_pkg::END_DONE) ? egdp_pkg::KIND_DONE
                                                              : egdp_pkg::KIND_ERROR;
              cmd.tail_err  = (adv_end == egdp_pkg::END_FAIL) ? egdp_pkg::ERR_OVERRUN
                                                              : egdp_pkg::ERR_NONE;
            end
          end
          egdp_pkg::PH_PRIV: begin
            push = 1'b1;
            cmd.head.kind = egdp_pkg::KIND_PRIV;
            cmd.head.private_value = b;
            cmd.tail_vld  = rem_dec == 8'd0;
            cmd.tail_kind = egdp_pkg::KIND_DONE;
            cmd.tail_err  = egdp_pkg::ERR_NONE;
          end
          default: push = 1'b0;
        endcase
      end
    end
    cmd.head.last = !cmd.tail_vld;
  end

  // Datapath next values.
  always_comb begin
    remain_nxt = remain_r;
    dlen_nxt   = dlen_r;
    events_nxt = events_r;
    idx_nxt    = idx_r;
    asm_nxt    = asm_r;
    grp_nxt    = grp_r;
    bufsz_nxt  = bufsz_r;
    if (acc) begin
      if (in_item.start_req) begin
        remain_nxt = 8'd0;
        dlen_nxt   = 8'd0;
        events_nxt = 4'd0;
        idx_nxt    = 3'd0;
        grp_nxt    = 4'd0;
        bufsz_nxt  = in_item.data_size;
      end else begin
        unique case (phase_r)
          egdp_pkg::PH_LEN: begin
            dlen_nxt   = b;
            remain_nxt = b;
          end
          egdp_pkg::PH_HEAD: begin
            grp_nxt    = b[7:4];
            events_nxt = b[3:0];
            remain_nxt = rem_dec;
            idx_nxt    = 3'd0;
          end
          egdp_pkg::PH_EVT, egdp_pkg::PH_RELAY: begin
            asm_nxt    = full_rec[55:0];
            remain_nxt = rem_dec;
            if ((phase_r == egdp_pkg::PH_EVT) ? evt_end : rly_end) begin
              idx_nxt = 3'd0;
              if (phase_r == egdp_pkg::PH_EVT) begin
                events_nxt = events_r - 4'd1;
              end
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end
          egdp_pkg::PH_PRIV: remain_nxt = rem_dec;
          default: remain_nxt = remain_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= egdp_pkg::PH_IDLE;
      remain_r <= 8'd0;
      dlen_r   <= 8'd0;
      events_r <= 4'd0;
      idx_r    <= 3'd0;
      grp_r    <= 4'd0;
      bufsz_r  <= 16'd0;
    end else begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      dlen_r   <= dlen_nxt;
      events_r <= events_nxt;
      idx_r    <= idx_nxt;
      grp_r    <= grp_nxt;
      bufsz_r  <= bufsz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
  end

endmodule

[hdl/egdp_fifo.sv]
module egdp_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  egdp_pkg::egdp_cmd_t   wr_data,
  input  logic                  pop,
  output egdp_pkg::egdp_cmd_t   rd_data,
  output egdp_pkg::egdp_fifo_stat_t stat
);

  egdp_pkg::egdp_cmd_t mem_r [egdp_pkg::FIFO_DEPTH];
  logic [egdp_pkg::FIFO_PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [egdp_pkg::FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == egdp_pkg::FIFO_CNT_W'(egdp_pkg::FIFO_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign rd_data    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + egdp_pkg::FIFO_PTR_W'(1) : wp_r;
    rp_nxt  = pop ? rp_r + egdp_pkg::FIFO_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + egdp_pkg::FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - egdp_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

[hdl/egdp_back.sv]
module egdp_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  egdp_pkg::egdp_cmd_t       q_data,
  input  egdp_pkg::egdp_fifo_stat_t q_stat,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output egdp_pkg::egdp_out_t       out_data
);

  logic                out_valid_r, out_valid_nxt;
  egdp_pkg::egdp_out_t out_data_r, out_data_nxt;
  logic                tail_pend_r, tail_pend_nxt;
  egdp_pkg::egdp_out_t tail_r, tail_nxt;
  egdp_pkg::egdp_out_t tail_build;
  logic                load_ok;

  assign load_ok = !out_valid_r || !out_stall;
  assign pop     = load_ok && !tail_pend_r && !q_stat.empty;

  always_comb begin
    tail_build                 = '0;
    tail_build.kind            = q_data.tail_kind;
    tail_build.grp_code        = q_data.head.grp_code;
    tail_build.error_code      = q_data.tail_err;
    tail_build.consumed_length = (q_data.tail_kind == egdp_pkg::KIND_DONE) ? q_data.tail_len
                                                                           : 9'd0;
    tail_build.last            = 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tail_pend_nxt = tail_pend_r;
    tail_nxt      = tail_r;
    if (load_ok) begin
      if (tail_pend_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = tail_r;
        tail_pend_nxt = 1'b0;
      end else if (!q_stat.empty) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = q_data.head;
        tail_pend_nxt = q_data.tail_vld;
        tail_nxt      = tail_build;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tail_pend_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      tail_pend_r <= tail_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    tail_r     <= tail_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/event_group_descriptor_parser.sv]
// Event group descriptor parser: one descriptor byte per cycle unless stalled.
// A result item passes through the queue and then the output register.
// Throughput: one byte in per cycle unless the queue is full, one result out
// per cycle unless stalled; a byte ending a record and the descriptor gives two.
// Reset (rst_n low, synchronous) returns the parser to idle and empties the queue.
module event_group_descriptor_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  egdp_pkg::egdp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output egdp_pkg::egdp_out_t out_data
);

  // The front end runs the byte-level parse state machine. Every byte that
  // produces results pushes one entry into a four-entry queue; the entry
  // carries the first result and, where the byte also closes the descriptor,
  // a done or error result to follow.
  // The back end drains the queue into the output register, unfolding a
  // two-result entry into its two results, so the front end keeps taking bytes
  // while a result waits for the consumer.

  logic                      in_acc;
  logic                      push;
  logic                      pop;
  egdp_pkg::egdp_cmd_t       wr_cmd;
  egdp_pkg::egdp_cmd_t       rd_cmd;
  egdp_pkg::egdp_fifo_stat_t q_stat;

  // The input is held off only while the queue is full; while the consumer
  // takes results, the queue keeps draining.
  assign in_stall = q_stat.full;
  assign in_acc   = in_valid && !in_stall;

  egdp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .in_item (in_data),
    .push    (push),
    .cmd     (wr_cmd)
  );

  egdp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_cmd),
    .pop     (pop),
    .rd_data (rd_cmd),
    .stat    (q_stat)
  );

  egdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (rd_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hdl/egdp_checker.sv]
module egdp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input egdp_pkg::egdp_out_t out_data
);

  // A held result must not change while the consumer stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A done result closes the descriptor and reports at least tag, length and header.
  a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == egdp_pkg::KIND_DONE |->
      out_data.last && out_data.consumed_length >= 9'd3 &&
      out_data.error_code == egdp_pkg::ERR_NONE)
    else $error("bad done result");

  // An error result carries a real code and is the last of its byte.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == egdp_pkg::KIND_ERROR |->
      out_data.last && out_data.error_code != egdp_pkg::ERR_NONE &&
      out_data.consumed_length == 9'd0)
    else $error("bad error result");

  // A record or private byte that is not last must be followed at once by
  // its terminating done or error result once the consumer takes it.
  a_tail_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && out_data.last &&
      (out_data.kind == egdp_pkg::KIND_DONE || out_data.kind == egdp_pkg::KIND_ERROR))
    else $error("missing terminating result");

endmodule

bind event_group_descriptor_parser egdp_checker u_egdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
